>>> rtl/wsad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsad_pkg
// Shared types and constants for the 5x5 SAD window cost core.
// ----------------------------------------------------------------------------
package wsad_pkg;

  localparam int PIX_W      = 8;
  localparam int WIN        = 5;
  localparam int HALF_WIN   = WIN / 2;
  localparam int HIST_D     = WIN - 1;
  localparam int COLSUM_W   = 11;
  localparam int COST_W     = 13;
  localparam int MAX_RES    = 3;
  localparam int RES_N_W    = 2;
  localparam int OUTQ_D     = 4;
  localparam int OUTQ_CNT_W = 3;

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [COLSUM_W-1:0] colsum_t;
  typedef logic [COST_W-1:0]   cost_t;

  typedef struct packed {
    pix_t [WIN-1:0] left;
    pix_t [WIN-1:0] right;
    logic           final_column;
  } item_t;

  typedef struct packed {
    cost_t cost;
    logic  final_flag;
  } result_t;

  typedef struct packed {
    logic [RES_N_W-1:0]        n;
    result_t [MAX_RES-1:0]     ent;
  } push_t;

endpackage

>>> rtl/wsad_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsad_if
// Valid/ready channels: pixel column in, window cost out.
// ----------------------------------------------------------------------------
interface wsad_in_if;
  logic          valid;
  logic          ready;
  wsad_pkg::pix_t left_row0;
  wsad_pkg::pix_t left_row1;
  wsad_pkg::pix_t left_row2;
  wsad_pkg::pix_t left_row3;
  wsad_pkg::pix_t left_row4;
  wsad_pkg::pix_t right_row0;
  wsad_pkg::pix_t right_row1;
  wsad_pkg::pix_t right_row2;
  wsad_pkg::pix_t right_row3;
  wsad_pkg::pix_t right_row4;
  logic          final_column;

  modport source (
    output valid, left_row0, left_row1, left_row2, left_row3, left_row4,
           right_row0, right_row1, right_row2, right_row3, right_row4, final_column,
    input  ready
  );
  modport sink (
    input  valid, left_row0, left_row1, left_row2, left_row3, left_row4,
           right_row0, right_row1, right_row2, right_row3, right_row4, final_column,
    output ready
  );
endinterface

interface wsad_out_if;
  logic           valid;
  logic           ready;
  wsad_pkg::cost_t window_cost;
  logic           final_cost;

  modport source (output valid, window_cost, final_cost, input ready);
  modport sink   (input valid, window_cost, final_cost, output ready);
endinterface

>>> rtl/wsad_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsad_cost
// Input register, column SAD, four-column history and window cost adders.
// ----------------------------------------------------------------------------
module wsad_cost #(
  parameter int STRIP_WIDTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  wsad_pkg::item_t item,
  input  logic            room,
  output logic            busy,
  output wsad_pkg::push_t push
);

  localparam int CNT_W = $clog2(STRIP_WIDTH);

  logic                                 stage_v_r;
  wsad_pkg::item_t                      stage_r;
  wsad_pkg::colsum_t [wsad_pkg::HIST_D-1:0] hist_r;
  logic [CNT_W-1:0]                     count_r;

  logic              fire;
  logic              last;
  logic              ge1;
  logic              ge2;
  wsad_pkg::pix_t    ad;
  wsad_pkg::colsum_t col_sum;
  wsad_pkg::cost_t   cost0;
  wsad_pkg::cost_t   cost1;
  wsad_pkg::cost_t   cost2;

  assign busy = stage_v_r && !room;
  assign fire = stage_v_r && room;

  always_comb begin
    col_sum = '0;
    ad      = '0;
    for (int r = 0; r < wsad_pkg::WIN; r++) begin
      ad = (stage_r.left[r] >= stage_r.right[r]) ? stage_r.left[r] - stage_r.right[r]
                                                 : stage_r.right[r] - stage_r.left[r];
      col_sum = col_sum + wsad_pkg::COLSUM_W'(ad);
    end
  end

  always_comb begin
    cost0 = wsad_pkg::COST_W'(col_sum) + wsad_pkg::COST_W'(hist_r[0])
          + wsad_pkg::COST_W'(hist_r[1]);
    cost1 = cost0 + wsad_pkg::COST_W'(hist_r[2]);
    cost2 = cost1 + wsad_pkg::COST_W'(hist_r[3]);
  end

  assign last = stage_r.final_column || (count_r == CNT_W'(STRIP_WIDTH - 1));
  assign ge1  = (count_r != '0);
  assign ge2  = (count_r >= CNT_W'(2));

  // results packed densely, oldest column first
  always_comb begin
    push = '0;
    push.ent[0].cost = cost2;
    push.ent[1].cost = cost1;
    push.ent[2].cost = cost0;
    if (fire) begin
      if (!last) begin
        push.n = ge2 ? wsad_pkg::RES_N_W'(1) : '0;
      end else if (ge2) begin
        push.n = wsad_pkg::RES_N_W'(3);
        push.ent[2].final_flag = 1'b1;
      end else if (ge1) begin
        push.n = wsad_pkg::RES_N_W'(2);
        push.ent[0].cost = cost1;
        push.ent[1].cost = cost0;
        push.ent[1].final_flag = 1'b1;
      end else begin
        push.n = wsad_pkg::RES_N_W'(1);
        push.ent[0].cost = cost0;
        push.ent[0].final_flag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (load) begin
      stage_v_r <= 1'b1;
    end else if (fire) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      if (last) begin
        hist_r  <= '0;
        count_r <= '0;
      end else begin
        for (int i = wsad_pkg::HIST_D - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= col_sum;
        count_r   <= count_r + CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/wsad_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsad_outq
// Four-entry result queue; up to three results in a cycle, one out per pop.
// ----------------------------------------------------------------------------
module wsad_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  wsad_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              head_v,
  output wsad_pkg::result_t head
);

  wsad_pkg::result_t [wsad_pkg::OUTQ_D-1:0] res_r;
  wsad_pkg::result_t [wsad_pkg::OUTQ_D-1:0] res_nxt;
  logic [wsad_pkg::OUTQ_CNT_W-1:0]          cnt_r;
  logic [wsad_pkg::OUTQ_CNT_W-1:0]          keep;
  logic                                     do_pop;

  assign head_v = (cnt_r != '0);
  assign head   = res_r[0];
  assign do_pop = pop && head_v;
  assign room   = (cnt_r <= wsad_pkg::OUTQ_CNT_W'(wsad_pkg::OUTQ_D - wsad_pkg::MAX_RES));
  assign keep   = cnt_r - wsad_pkg::OUTQ_CNT_W'(do_pop);

  always_comb begin
    logic [wsad_pkg::OUTQ_CNT_W-1:0] idx;
    idx     = '0;
    res_nxt = res_r;
    for (int j = 0; j < wsad_pkg::OUTQ_D; j++) begin
      if (wsad_pkg::OUTQ_CNT_W'(j) < keep) begin
        if (do_pop && (j + 1 < wsad_pkg::OUTQ_D)) begin
          res_nxt[j] = res_r[(j + 1) % wsad_pkg::OUTQ_D];
        end
      end else begin
        idx = wsad_pkg::OUTQ_CNT_W'(j) - keep;
        if (idx < wsad_pkg::OUTQ_CNT_W'(push.n)) begin
          res_nxt[j] = push.ent[idx[wsad_pkg::RES_N_W-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= keep + wsad_pkg::OUTQ_CNT_W'(push.n);
    end
  end

endmodule

>>> rtl/window_sad_cost_5x5_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_sad_cost_5x5_core
// 5x5 sum-of-absolute-differences window cost over a five-row strip.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  in_chan    in   valid/ready    left_row0..4, right_row0..4, final_column
//  out_chan   out  valid/ready    window_cost, final_cost
//
//  One column item is taken per clock unless the input stalls; its cost
//  passes through the input register, then the result queue.
//  A last column yields up to three costs, drained one per clock, when
//  out_chan is ready, from the four-entry queue; input stalls while
//  the queue holds more than one cost. Synchronous active-low reset empties
//  the input register and queue and clears the column history and count.
// ----------------------------------------------------------------------------
module window_sad_cost_5x5_core #(
  parameter int STRIP_WIDTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  wsad_in_if.sink           in_chan,
  wsad_out_if.source        out_chan
);

  wsad_pkg::item_t   item;
  wsad_pkg::push_t   push;
  wsad_pkg::result_t head;
  logic              room;
  logic              busy;
  logic              head_v;
  logic              load;

  always_comb begin
    item.left[0]      = in_chan.left_row0;
    item.left[1]      = in_chan.left_row1;
    item.left[2]      = in_chan.left_row2;
    item.left[3]      = in_chan.left_row3;
    item.left[4]      = in_chan.left_row4;
    item.right[0]     = in_chan.right_row0;
    item.right[1]     = in_chan.right_row1;
    item.right[2]     = in_chan.right_row2;
    item.right[3]     = in_chan.right_row3;
    item.right[4]     = in_chan.right_row4;
    item.final_column = in_chan.final_column;
  end

  assign in_chan.ready = !busy;
  assign load          = in_chan.valid && !busy;

  wsad_cost #(
    .STRIP_WIDTH(STRIP_WIDTH)
  ) u_cost (
    .clk  (clk),
    .rst_n(rst_n),
    .load (load),
    .item (item),
    .room (room),
    .busy (busy),
    .push (push)
  );

  wsad_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_chan.ready),
    .room  (room),
    .head_v(head_v),
    .head  (head)
  );

  assign out_chan.valid       = head_v;
  assign out_chan.window_cost = head.cost;
  assign out_chan.final_cost  = head.final_flag;

endmodule
